>>> design/cc32_pkg.sv
// shared types, constants and the byte fold function of the chunked crc-32 unit
package cc32_pkg;

	localparam int unsigned CrcWidth = 32;
	localparam int unsigned ByteWidth = 8;
	localparam logic [CrcWidth-1:0] CrcPoly = 32'hEDB8_8320;
	localparam logic [CrcWidth-1:0] CrcAllOnes = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [ByteWidth-1:0] data_byte;
		logic                 byte_valid;
		logic                 start_req;
		logic                 chunk_end;
	} item_t;

	// reflected crc, lsb first, one bit per step
	function automatic logic [CrcWidth-1:0] crc_fold_byte(
		input logic [CrcWidth-1:0]  crc,
		input logic [ByteWidth-1:0] data
	);
		logic [CrcWidth-1:0] v;
		v = crc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
		for (int k = 0; k < ByteWidth; k++) begin
			if (v[0]) begin
				v = (v >> 1) ^ CrcPoly;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

endpackage

>>> design/cc32_fold.sv
// next running crc for one word: reload, byte fold, chunk-end inversion
module cc32_fold (
	input  logic [cc32_pkg::CrcWidth-1:0] crc_in,
	input  cc32_pkg::item_t               item,
	output logic [cc32_pkg::CrcWidth-1:0] crc_out
);
	import cc32_pkg::*;

	logic [CrcWidth-1:0] base;
	logic [CrcWidth-1:0] folded;

	always_comb begin
		base = item.start_req ? CrcAllOnes : crc_in;
		folded = item.byte_valid ? crc_fold_byte(base, item.data_byte) : base;
		crc_out = item.chunk_end ? (folded ^ CrcAllOnes) : folded;
	end

endmodule

>>> design/crc32_chunked_checksum.sv
// Chunked CRC-32 (reflected, polynomial 0xEDB88320). Each accepted word is loaded into an
// input register. When it advances, its byte (if valid) is folded into the running value,
// which start_req first reloads to all ones. On chunk end, the same edge also loads the inverted
// value into the output register and keeps it as the running value. Throughput is one word per
// clock while in_stall is low. A word passes the input register, then the combinational byte
// fold, then the result register before crc_value is valid. in_stall rises only while a chunk-end
// word waits behind a stalled, full output register.
module crc32_chunked_checksum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cc32_pkg::ByteWidth-1:0] data_byte,
	input  logic                          byte_valid,
	input  logic                          start_req,
	input  logic                          chunk_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cc32_pkg::CrcWidth-1:0] crc_value
);
	import cc32_pkg::*;

	item_t               item_s1;
	logic                valid_s1;
	logic [CrcWidth-1:0] crc_q;
	logic [CrcWidth-1:0] crc_next;
	logic                out_valid_q;
	logic [CrcWidth-1:0] crc_value_q;
	logic                advance;
	logic                in_acc;

	// a word without chunk end never needs the output register
	assign advance = valid_s1 && (!item_s1.chunk_end || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_acc = in_valid && !in_stall;

	cc32_fold u_fold (
		.crc_in (crc_q),
		.item   (item_s1),
		.crc_out(crc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			crc_q <= CrcAllOnes;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= in_stall ? 1'b1 : in_acc;
			if (advance) begin
				crc_q <= crc_next;
			end
			if (advance && item_s1.chunk_end) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1 <= '{data_byte: data_byte, byte_valid: byte_valid,
				start_req: start_req, chunk_end: chunk_end};
		end
		if (advance && item_s1.chunk_end) begin
			crc_value_q <= crc_next;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_value_q;

endmodule

>>> design/cc32_checker.sv
// port-level checks for the chunked crc-32 unit and their bind
module cc32_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [cc32_pkg::CrcWidth-1:0] crc_value
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(crc_value))
		else $error("crc_value changed while stalled");

	// input backs up only behind a stalled full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without output backpressure");

	// a fresh result comes from a word that was accepted into the input register
	a_rose_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without matching input word");

endmodule

bind crc32_chunked_checksum cc32_checker u_cc32_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.crc_value(crc_value)
);
